// ===== sv/walt_pkg.sv =====
// Shared types and constants for the wifi address learning table.
// Holds the table geometry, frame decode codes and the query record that
// travels down the cell chain. No dependencies.
`default_nettype none

package walt_pkg;

	// Table geometry and field widths
	localparam int TABLE_DEPTH = 256;
	localparam int COUNT_BITS  = 32;
	localparam int ADDR_BITS   = 48;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int UNIQ_W      = $clog2(TABLE_DEPTH + 1);

	// Register index of the configuration port (word index)
	localparam logic REG_CAPTURE_ENABLE = 1'b0;

	// Frame types (frame control bits 3:2)
	localparam logic [1:0] TYPE_MGMT = 2'd0;
	localparam logic [1:0] TYPE_CTRL = 2'd1;
	localparam logic [1:0] TYPE_DATA = 2'd2;

	// Control subtypes (frame control bits 7:4)
	localparam logic [3:0] SUB_PS_POLL = 4'ha;
	localparam logic [3:0] SUB_RTS     = 4'hb;
	localparam logic [3:0] SUB_CTS     = 4'hc;
	localparam logic [3:0] SUB_ACK     = 4'hd;
	localparam logic [3:0] SUB_CF_END  = 4'he;

	// Both DS bits set marks a four-address data frame
	localparam logic [1:0] DS_BOTH = 2'b11;

	// Shortest header that is learned
	localparam logic [15:0] MIN_FRAME_LEN = 16'd24;

	// One address lookup on its way down the chain
	typedef struct packed {
		logic                  valid;
		logic                  done;
		logic                  is_new;
		logic                  last;
		logic [ADDR_BITS-1:0]  addr;
		logic [SLOT_W-1:0]     slot;
		logic [COUNT_BITS-1:0] cnt;
	} walt_query_t;

endpackage

`default_nettype wire

// ===== sv/wifi_address_learning_table.sv =====
// Top level of the wifi address learning table: config register, frame
// sequencer, the chain of table cells and the result register.
// Depends on walt_pkg, walt_issue and walt_cell.
//
//  port group   | handshake                        | moves
//  -------------+----------------------------------+-----------------------------
//  config (APB) | psel & penable & pwrite & pready | capture_enable at word 0
//  frame in     | start & !busy                    | one frame header item
//  result out   | result_valid, one cycle          | one item per used address
//
// The sequencer feeds a frame's used addresses (1 to 4) into the chain one per
// cycle; a frame that is dropped or uses none feeds nothing. busy is high while
// addresses are still being fed in. Each address walks the TABLE_DEPTH-cell
// chain, one cell per cycle, from the sequencer's query register through each
// cell's register into the result register.
// Reset clears all valid marks at once; no clearing pass is needed.
// The receiver cannot stall: results leave in order, one per cycle at most.
`default_nettype none

module wifi_address_learning_table (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [2:0]                     paddr,
	input  wire  [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  wire                            start,
	output logic                           busy,
	input  wire  [7:0]                     frame_control_low,
	input  wire  [7:0]                     frame_flags,
	input  wire  [15:0]                    captured_length,
	input  wire  [walt_pkg::ADDR_BITS-1:0] address_one,
	input  wire  [walt_pkg::ADDR_BITS-1:0] address_two,
	input  wire  [walt_pkg::ADDR_BITS-1:0] address_three,
	input  wire  [walt_pkg::ADDR_BITS-1:0] address_four,
	output logic                           result_valid,
	output logic [walt_pkg::ADDR_BITS-1:0] seen_address,
	output logic                           is_new,
	output logic [7:0]                     entry_slot,
	output logic [31:0]                    sighting_count,
	output logic                           table_full,
	output logic [8:0]                     unique_total,
	output logic [31:0]                    address_total,
	output logic                           last_of_frame
);
	import walt_pkg::*;

	logic                 cap_q;
	walt_query_t          chain [0:TABLE_DEPTH];
	walt_query_t          tail;

	logic                 result_valid_q;
	logic [ADDR_BITS-1:0] seen_q;
	logic                 is_new_q;
	logic [7:0]           slot_q;
	logic [31:0]          cnt_q;
	logic                 full_q;
	logic                 last_q;
	logic [UNIQ_W-1:0]    uniq_q;
	logic [31:0]          tot_q;

	// Configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPTURE_ENABLE) begin
			cap_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2] == REG_CAPTURE_ENABLE) ? {31'd0, cap_q} : 32'd0;

	// Feed frame addresses into the chain
	walt_issue u_issue (
		.clk               (clk),
		.arst_n            (arst_n),
		.capture_en        (cap_q),
		.start             (start),
		.busy              (busy),
		.frame_control_low (frame_control_low),
		.frame_flags       (frame_flags),
		.captured_length   (captured_length),
		.address_one       (address_one),
		.address_two       (address_two),
		.address_three     (address_three),
		.address_four      (address_four),
		.q_out             (chain[0])
	);

	// Row of table cells, one entry each
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		walt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_index (SLOT_W'(i)),
			.q_in       (chain[i]),
			.q_out      (chain[i+1])
		);
	end

	assign tail = chain[TABLE_DEPTH];

	// Totals and result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			uniq_q         <= '0;
			tot_q          <= 32'd0;
		end else begin
			result_valid_q <= tail.valid;
			if (tail.valid) begin
				uniq_q <= uniq_q + UNIQ_W'(tail.is_new);
				if (tot_q != 32'hFFFF_FFFF) begin
					tot_q <= tot_q + 32'd1;
				end
			end
		end
	end

	// Capture the item leaving the chain
	always_ff @(posedge clk) begin
		if (tail.valid) begin
			seen_q   <= tail.addr;
			is_new_q <= tail.is_new;
			slot_q   <= 8'(tail.slot);
			cnt_q    <= 32'(tail.cnt);
			full_q   <= !tail.done;
			last_q   <= tail.last;
		end
	end

	assign result_valid   = result_valid_q;
	assign seen_address   = seen_q;
	assign is_new         = is_new_q;
	assign entry_slot     = slot_q;
	assign sighting_count = cnt_q;
	assign table_full     = full_q;
	assign unique_total   = 9'(uniq_q);
	assign address_total  = tot_q;
	assign last_of_frame  = last_q;

	// A full table is only reported once every slot is taken
	a_full_means_all_taken: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && full_q |-> uniq_q == UNIQ_W'(TABLE_DEPTH))
		else $error("table full reported with free slots");

	// An insertion never coincides with a full report
	a_new_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> !(is_new_q && full_q))
		else $error("item both inserted and rejected");

	// A freshly inserted address starts at one sighting
	a_new_count_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && is_new_q |-> cnt_q == 32'd1)
		else $error("new entry count is not one");

	// Unique count never exceeds the table size
	a_uniq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		uniq_q <= UNIQ_W'(TABLE_DEPTH))
		else $error("unique count beyond table depth");

	// Each item leaving the chain raises the unique count by its insert flag
	a_uniq_step: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |=> uniq_q == $past(uniq_q) + UNIQ_W'($past(tail.is_new)))
		else $error("unique count out of step");

endmodule

`default_nettype wire

// ===== sv/walt_cell.sv =====
// One table entry of the learning chain: stores an address and its count,
// matches or claims a passing query and hands it to the next cell.
// Depends on walt_pkg.
`default_nettype none

module walt_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  [walt_pkg::SLOT_W-1:0] cell_index,
	input  wire  walt_pkg::walt_query_t q_in,
	output walt_pkg::walt_query_t       q_out
);
	import walt_pkg::*;

	logic                  vld_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [COUNT_BITS-1:0] cnt_q;
	walt_query_t           q_q;
	walt_query_t           q_next;

	logic                  take;
	logic                  hit;
	logic                  claim;
	logic [COUNT_BITS-1:0] cnt_next;

	// Match against the stored entry; the first empty cell takes a miss
	assign take     = q_in.valid && !q_in.done;
	assign hit      = take && vld_q && (addr_q == q_in.addr);
	assign claim    = take && !vld_q;
	assign cnt_next = (cnt_q == {COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + COUNT_BITS'(1);

	// Mark the query done where it matches or claims this entry
	always_comb begin
		q_next = q_in;
		if (hit) begin
			q_next.done   = 1'b1;
			q_next.is_new = 1'b0;
			q_next.slot   = cell_index;
			q_next.cnt    = cnt_next;
		end else if (claim) begin
			q_next.done   = 1'b1;
			q_next.is_new = 1'b1;
			q_next.slot   = cell_index;
			q_next.cnt    = COUNT_BITS'(1);
		end
	end

	// Hold the valid mark and advance the query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			q_q   <= '0;
		end else begin
			q_q <= q_next;
			if (claim) begin
				vld_q <= 1'b1;
			end
		end
	end

	// Update the entry payload
	always_ff @(posedge clk) begin
		if (claim) begin
			addr_q <= q_in.addr;
			cnt_q  <= COUNT_BITS'(1);
		end else if (hit) begin
			cnt_q <= cnt_next;
		end
	end

	assign q_out = q_q;

endmodule

`default_nettype wire

// ===== sv/walt_issue.sv =====
// Frame decoder and address sequencer: filters frames, counts the used
// addresses and feeds them into the cell chain one per cycle.
// Depends on walt_pkg.
`default_nettype none

module walt_issue (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            capture_en,
	input  wire                            start,
	output logic                           busy,
	input  wire  [7:0]                     frame_control_low,
	input  wire  [7:0]                     frame_flags,
	input  wire  [15:0]                    captured_length,
	input  wire  [walt_pkg::ADDR_BITS-1:0] address_one,
	input  wire  [walt_pkg::ADDR_BITS-1:0] address_two,
	input  wire  [walt_pkg::ADDR_BITS-1:0] address_three,
	input  wire  [walt_pkg::ADDR_BITS-1:0] address_four,
	output walt_pkg::walt_query_t          q_out
);
	import walt_pkg::*;

	logic [1:0]           ftype;
	logic [3:0]           fsub;
	logic [2:0]           n_used;
	logic                 accept;
	logic                 launch;
	logic [1:0]           rem_q;
	logic [ADDR_BITS-1:0] a2_q;
	logic [ADDR_BITS-1:0] a3_q;
	logic [ADDR_BITS-1:0] a4_q;
	walt_query_t          q_q;

	assign ftype = frame_control_low[3:2];
	assign fsub  = frame_control_low[7:4];

	// Count the addresses this frame kind carries
	always_comb begin
		n_used = 3'd0;
		case (ftype)
			TYPE_MGMT: n_used = 3'd3;
			TYPE_DATA: n_used = (frame_flags[1:0] == DS_BOTH) ? 3'd4 : 3'd3;
			TYPE_CTRL: begin
				if (fsub == SUB_PS_POLL || fsub == SUB_RTS || fsub == SUB_CF_END) begin
					n_used = 3'd2;
				end else if (fsub == SUB_CTS || fsub == SUB_ACK) begin
					n_used = 3'd1;
				end
			end
			default: n_used = 3'd0;
		endcase
	end

	assign busy   = (rem_q != 2'd0);
	assign accept = start && !busy;
	assign launch = accept && capture_en && (captured_length >= MIN_FRAME_LEN)
		&& (n_used != 3'd0);

	// Sequence control: remaining addresses and the query leaving for the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			q_q   <= '0;
		end else if (launch) begin
			rem_q     <= 2'(n_used - 3'd1);
			q_q.valid <= 1'b1;
			q_q.addr  <= address_one;
			q_q.last  <= (n_used == 3'd1);
		end else if (busy) begin
			rem_q     <= rem_q - 2'd1;
			q_q.valid <= 1'b1;
			q_q.addr  <= a2_q;
			q_q.last  <= (rem_q == 2'd1);
		end else begin
			q_q.valid <= 1'b0;
		end
	end

	// Load the frame addresses, then shift one up each cycle
	always_ff @(posedge clk) begin
		if (launch) begin
			a2_q <= address_two;
			a3_q <= address_three;
			a4_q <= address_four;
		end else begin
			a2_q <= a3_q;
			a3_q <= a4_q;
		end
	end

	assign q_out = q_q;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the wifi address learning table.
// Drives frame headers and the APB capture register, predicts each sighting result.
// Depends on walt_pkg and wifi_address_learning_table.

module testbench;
	import walt_pkg::*;

	localparam logic [1:0] TYPE_RSVD = 2'd3;
	localparam logic [2:0] CAPTURE_ADDR = {REG_CAPTURE_ENABLE, 2'b00};
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
	localparam int CYCLE_LIMIT = 100000;
	localparam int POOL_SIZE = 24;

	typedef struct packed {
		logic [7:0]                     fc;
		logic [7:0]                     flags;
		logic [15:0]                    len;
		logic [3:0][ADDR_BITS-1:0]      addr;
	} frame_t;

	// Field order matches the concatenation of the result ports below
	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic                 fresh;
		logic [7:0]           slot;
		logic [31:0]          count;
		logic                 full;
		logic [8:0]           uniq;
		logic [31:0]          total;
		logic                 last;
	} sighting_t;

	// Learning table predictor and the queue of sightings it expects
	class address_table_model;
		logic [ADDR_BITS-1:0]  slot_addr [TABLE_DEPTH];
		logic [COUNT_BITS-1:0] slot_count [TABLE_DEPTH];
		bit                    slot_used [TABLE_DEPTH];
		int                    uniq_count;
		logic [31:0]           seen_total;
		bit                    capture_on;
		sighting_t             expected_sightings[$];
		int                    mismatches;

		function new();
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			uniq_count = 0;
			seen_total = '0;
			capture_on = 1'b1;
			mismatches = 0;
		endfunction

		function void set_capture(bit on);
			capture_on = on;
		endfunction

		function int pending();
			return expected_sightings.size();
		endfunction

		// Number of leading address slots a frame carries
		function int frame_words(logic [7:0] fc, logic [7:0] flags);
			case (fc[3:2])
				TYPE_MGMT: return 3;
				TYPE_DATA: return (flags[1:0] == DS_BOTH) ? 4 : 3;
				TYPE_CTRL: begin
					if (fc[7:4] == SUB_PS_POLL || fc[7:4] == SUB_RTS || fc[7:4] == SUB_CF_END)
						return 2;
					if (fc[7:4] == SUB_CTS || fc[7:4] == SUB_ACK)
						return 1;
					return 0;
				end
				default: return 0;
			endcase
		endfunction

		// Look up one address, then bump or insert it
		function sighting_t learn(logic [ADDR_BITS-1:0] a);
			sighting_t s;
			int hit;
			int free_idx;
			hit = -1;
			free_idx = -1;
			if (seen_total != '1) seen_total++;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (slot_used[i]) begin
					if (hit < 0 && slot_addr[i] == a) hit = i;
				end else if (free_idx < 0) begin
					free_idx = i;
				end
			end
			s = '0;
			s.addr = a;
			if (hit >= 0) begin
				if (slot_count[hit] != '1) slot_count[hit]++;
				s.slot = 8'(hit);
				s.count = 32'(slot_count[hit]);
			end else if (free_idx >= 0) begin
				slot_addr[free_idx] = a;
				slot_count[free_idx] = COUNT_BITS'(1);
				slot_used[free_idx] = 1'b1;
				uniq_count++;
				s.fresh = 1'b1;
				s.slot = 8'(free_idx);
				s.count = 32'd1;
			end else begin
				s.full = 1'b1;
			end
			s.uniq = 9'(uniq_count);
			s.total = seen_total;
			return s;
		endfunction

		// Note an accepted frame; returns how many sightings it causes
		function int note_frame(frame_t f);
			int n;
			sighting_t s;
			if (!capture_on || f.len < MIN_FRAME_LEN) return 0;
			n = frame_words(f.fc, f.flags);
			for (int k = 0; k < n; k++) begin
				s = learn(f.addr[k]);
				s.last = (k == n - 1);
				expected_sightings = {expected_sightings, s};
			end
			return n;
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %h, got %h", name, want, got);
				mismatches++;
			end
		endfunction

		// Compare one sighting against the oldest expected one
		function void check_sighting(sighting_t got);
			sighting_t want;
			if (expected_sightings.size() == 0) begin
				$error("unexpected result for address %h", got.addr);
				mismatches++;
				return;
			end
			want = expected_sightings.pop_front();
			compare_field("seen_address", want.addr, got.addr);
			compare_field("is_new", want.fresh, got.fresh);
			compare_field("entry_slot", want.slot, got.slot);
			compare_field("sighting_count", want.count, got.count);
			compare_field("table_full", want.full, got.full);
			compare_field("unique_total", want.uniq, got.uniq);
			compare_field("address_total", want.total, got.total);
			compare_field("last_of_frame", want.last, got.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [7:0] frame_control_low;
	logic [7:0] frame_flags;
	logic [15:0] captured_length;
	logic [ADDR_BITS-1:0] address_one, address_two, address_three, address_four;
	logic result_valid;
	logic [ADDR_BITS-1:0] seen_address;
	logic is_new;
	logic [7:0] entry_slot;
	logic [31:0] sighting_count;
	logic table_full;
	logic [8:0] unique_total;
	logic [31:0] address_total;
	logic last_of_frame;
	sighting_t observed;

	address_table_model sb;
	logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];
	int burst_left;
	int unsigned cycle_count = 0;

	wifi_address_learning_table DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.frame_control_low(frame_control_low), .frame_flags(frame_flags),
		.captured_length(captured_length),
		.address_one(address_one), .address_two(address_two),
		.address_three(address_three), .address_four(address_four),
		.result_valid(result_valid), .seen_address(seen_address), .is_new(is_new),
		.entry_slot(entry_slot), .sighting_count(sighting_count),
		.table_full(table_full), .unique_total(unique_total),
		.address_total(address_total), .last_of_frame(last_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check every result in the cycle it is shown
	assign observed = {seen_address, is_new, entry_slot, sighting_count, table_full,
		unique_total, address_total, last_of_frame};

	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_sighting(observed);
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic logic [ADDR_BITS-1:0] rand_addr();
		logic [15:0] hi;
		logic [31:0] lo;
		hi = 16'($urandom);
		lo = $urandom;
		return {hi, lo};
	endfunction

	// Mix repeat sightings from the pool with fresh addresses
	function automatic logic [ADDR_BITS-1:0] pick_addr();
		if ($urandom_range(0, 99) < 45) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		return rand_addr();
	endfunction

	function automatic logic [7:0] fc_of(logic [1:0] kind, logic [3:0] sub);
		return {sub, kind, 2'($urandom)};
	endfunction

	function automatic frame_t mk_frame(logic [7:0] fc, logic [7:0] flags, logic [15:0] len,
			logic [ADDR_BITS-1:0] a1, logic [ADDR_BITS-1:0] a2,
			logic [ADDR_BITS-1:0] a3, logic [ADDR_BITS-1:0] a4);
		frame_t f;
		f.fc = fc;
		f.flags = flags;
		f.len = len;
		f.addr[0] = a1;
		f.addr[1] = a2;
		f.addr[2] = a3;
		f.addr[3] = a4;
		return f;
	endfunction

	// Mostly well-formed frames, some short or addressless noise
	function automatic frame_t rand_frame();
		frame_t f;
		int pick;
		logic [3:0] ctrl_subs [5];
		ctrl_subs = '{SUB_PS_POLL, SUB_RTS, SUB_CTS, SUB_ACK, SUB_CF_END};
		pick = $urandom_range(0, 99);
		f = mk_frame(8'($urandom), 8'($urandom), 16'($urandom_range(MIN_FRAME_LEN, 65535)),
			pick_addr(), pick_addr(), pick_addr(), pick_addr());
		if ($urandom_range(0, 4) == 0) f.len = 16'($urandom_range(MIN_FRAME_LEN, 30));
		if (pick < 35) begin
			f.fc = fc_of(TYPE_MGMT, 4'($urandom));
		end else if (pick < 70) begin
			f.fc = fc_of(TYPE_DATA, 4'($urandom));
			if ($urandom_range(0, 9) < 4) f.flags[1:0] = DS_BOTH;
		end else if (pick < 85) begin
			f.fc = fc_of(TYPE_CTRL, ctrl_subs[$urandom_range(0, 4)]);
		end else if (pick < 90) begin
			f.fc = ($urandom_range(0, 1) == 0) ? fc_of(TYPE_RSVD, 4'($urandom)) :
				fc_of(TYPE_CTRL, 4'($urandom_range(0, 9)));
		end else begin
			f.len = 16'($urandom_range(0, MIN_FRAME_LEN - 1));
		end
		return f;
	endfunction

	// Present one frame and hold it until the block takes it
	task automatic send_frame(input frame_t f, output int produced);
		frame_control_low <= f.fc;
		frame_flags <= f.flags;
		captured_length <= f.len;
		address_one <= f.addr[0];
		address_two <= f.addr[1];
		address_three <= f.addr[2];
		address_four <= f.addr[3];
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		produced = sb.note_frame(f);
	endtask

	// Keep start high within a burst, else drop it for a random gap
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 10);
		end
	endtask

	// Go idle, drain all expected results and let the cell chain empty
	task automatic settle();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capture(input bit on);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPTURE_ADDR;
		pwdata <= {31'($urandom), on};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_capture(on);
	endtask

	task automatic run_random(input int want);
		int done;
		int n;
		done = 0;
		while (done < want) begin
			send_frame(rand_frame(), n);
			if (n > 0) done++;
			pace();
		end
	endtask

	task automatic run_ignored(input int frames);
		int n;
		repeat (frames) begin
			send_frame(rand_frame(), n);
			pace();
		end
	endtask

	task automatic run_directed();
		frame_t f [$];
		int n;
		logic [3:0] subs [7];
		subs = '{4'h0, SUB_PS_POLL, SUB_RTS, SUB_CTS, SUB_ACK, SUB_CF_END, 4'hf};
		f = {f, mk_frame(fc_of(TYPE_MGMT, 4'h0), 8'h00, MIN_FRAME_LEN,
			'0, '1, addr_pool[2], addr_pool[3])};
		f = {f, mk_frame(fc_of(TYPE_MGMT, 4'h8), 8'hff, MIN_FRAME_LEN - 1,
			addr_pool[4], addr_pool[5], addr_pool[6], addr_pool[7])};
		f = {f, mk_frame(fc_of(TYPE_DATA, 4'h0), 8'h03, 16'd0,
			addr_pool[4], addr_pool[5], addr_pool[6], addr_pool[7])};
		f = {f, mk_frame(fc_of(TYPE_DATA, 4'h8), 8'h00, 16'hffff,
			'1, '0, addr_pool[4], addr_pool[5])};
		// four-address frame too short to hold its fourth address
		f = {f, mk_frame(fc_of(TYPE_DATA, 4'h0), {6'($urandom), DS_BOTH}, 16'd25,
			addr_pool[5], addr_pool[6], addr_pool[7], 48'h0123_4567_89ab)};
		f = {f, mk_frame(fc_of(TYPE_DATA, 4'hf), 8'hff, 16'd30,
			rand_addr(), rand_addr(), addr_pool[8], addr_pool[9])};
		f = {f, mk_frame(fc_of(TYPE_DATA, 4'h4), 8'h01, 16'd100,
			addr_pool[9], addr_pool[10], addr_pool[11], rand_addr())};
		f = {f, mk_frame(fc_of(TYPE_DATA, 4'hc), 8'hfe, 16'd1500,
			addr_pool[12], addr_pool[9], addr_pool[10], rand_addr())};
		foreach (subs[i])
			f = {f, mk_frame(fc_of(TYPE_CTRL, subs[i]), 8'($urandom), 16'd24 + 16'(i),
				addr_pool[13 + i], addr_pool[1], rand_addr(), rand_addr())};
		f = {f, mk_frame(fc_of(TYPE_RSVD, 4'h5), 8'h03, 16'd64,
			rand_addr(), rand_addr(), rand_addr(), rand_addr())};
		// repeat the first frame so every address hits
		f = {f, mk_frame({4'hf, TYPE_MGMT, 2'b11}, 8'h5a, 16'd200,
			'0, '1, addr_pool[2], rand_addr())};
		foreach (f[i]) begin
			send_frame(f[i], n);
			pace();
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		frame_control_low <= '0;
		frame_flags <= '0;
		captured_length <= '0;
		address_one <= '0;
		address_two <= '0;
		address_three <= '0;
		address_four <= '0;
		burst_left = 0;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = rand_addr();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		settle();
		write_capture(1'b0);
		run_ignored(10);
		settle();
		write_capture(1'b1);
		run_random(85);
		settle();
		write_capture(1'b0);
		run_ignored(6);
		settle();
		write_capture(1'b1);
		run_random(85);
		settle();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
